// ===== hdl/msr_pkg.sv =====
// Package: shared types and constants for the MIDI SysEx router and pacer.
`timescale 1ns / 1ps
package msr_pkg;

	localparam int BUFFER_DEPTH_DEF = 8192;
	localparam int LEN_W            = 14;
	localparam int QUEUE_DEPTH      = 4;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 16;

	localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
	localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
	localparam logic [7:0] BYTE_REALTIME    = 8'hF8;
	localparam logic [LEN_W-1:0] LEN_MAX    = {LEN_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIN_THRU    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_DELAY  = 2'd2;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_EMIT  = 2'd1,
		OP_READ  = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [7:0]       data;
		logic [LEN_W-1:0] addr;
		logic             to_din;
		logic             to_usb;
		logic             last;
		logic             zero;
	} op_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] midi_byte;
		logic       from_usb;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       to_din;
		logic       to_usb;
		logic       replay_last;
	} out_item_t;

endpackage

// ===== hdl/midi_sysex_router_pacer_unit.sv =====
// Top level: MIDI byte router with SysEx buffering and paced replay.
// Throughput: one item per cycle, input and output sides stall independently.
// An accepted item passes the queue slot, the store read stage and the output register,
// in that order, before out_valid rises.
// Reset: arst_n clears control state and loads register defaults; the store is not cleared.
`timescale 1ns / 1ps
module midi_sysex_router_pacer_unit import msr_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	logic push, q_full, q_valid, pop;
	op_t  push_op, q_op;

	msr_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .in_data,
		.push, .push_op, .q_full
	);

	msr_queue u_queue (
		.clk, .arst_n, .push, .push_op, .full(q_full),
		.pop, .q_valid, .q_op
	);

	msr_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_op, .pop,
		.out_valid, .out_ready, .out_data
	);

endmodule

// ===== hdl/msr_front.sv =====
// Front end: configuration, routing decisions, SysEx capture and replay pacing.
`timescale 1ns / 1ps
module msr_front import msr_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  push,
	output op_t                   push_op,
	input  logic                  q_full
);

	localparam logic [LEN_W:0] DEPTH_W = (LEN_W+1)'(BUFFER_DEPTH);

	logic             stream_mode_q, din_thru_q;
	logic [15:0]      byte_delay_q;
	logic             in_message_q, overflowed_q, replay_active_q;
	logic             replay_din_q, replay_usb_q;
	logic [LEN_W-1:0] msg_length_q, replay_index_q;
	logic [15:0]      pace_count_q;

	logic             in_message_d, overflowed_d, replay_active_d;
	logic             replay_din_d, replay_usb_d;
	logic [LEN_W-1:0] msg_length_d, replay_index_d;
	logic [15:0]      pace_count_d;
	logic             op_valid;
	op_t              op;

	logic             to_d, to_u, room, accept;
	logic [LEN_W-1:0] len_inc;
	logic [15:0]      pace_inc, interval;
	logic [7:0]       b;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && op_valid;
	assign push_op  = op;

	always_comb begin
		b        = in_data.midi_byte;
		to_d     = in_data.from_usb || din_thru_q;
		to_u     = !in_data.from_usb;
		room     = ({1'b0, msg_length_q} < DEPTH_W) && (msg_length_q != LEN_MAX);
		len_inc  = (msg_length_q != LEN_MAX) ? msg_length_q + 1'b1 : msg_length_q;
		pace_inc = (pace_count_q != 16'hFFFF) ? pace_count_q + 1'b1 : pace_count_q;
		interval = (byte_delay_q == 16'd0) ? 16'd1 : byte_delay_q;

		in_message_d    = in_message_q;
		overflowed_d    = overflowed_q;
		replay_active_d = replay_active_q;
		replay_din_d    = replay_din_q;
		replay_usb_d    = replay_usb_q;
		msg_length_d    = msg_length_q;
		replay_index_d  = replay_index_q;
		pace_count_d    = pace_count_q;

		op_valid   = 1'b0;
		op.kind    = OP_EMIT;
		op.data    = b;
		op.addr    = msg_length_q;
		op.to_din  = to_d;
		op.to_usb  = to_u;
		op.last    = 1'b0;
		op.zero    = 1'b0;

		if (in_data.req_type == REQ_TICK) begin
			if (replay_active_q) begin
				if (pace_inc >= interval) begin
					pace_count_d   = 16'd0;
					op_valid       = 1'b1;
					op.kind        = OP_READ;
					op.addr        = replay_index_q;
					op.to_din      = replay_din_q;
					op.to_usb      = replay_usb_q;
					op.last        = ({1'b0, replay_index_q} + 1'b1) >= {1'b0, msg_length_q};
					op.zero        = {1'b0, replay_index_q} >= DEPTH_W;
					replay_index_d = replay_index_q + 1'b1;
					if (op.last)
						replay_active_d = 1'b0;
				end else begin
					pace_count_d = pace_inc;
				end
			end
		end else if (!replay_active_q) begin
			if (b >= BYTE_REALTIME) begin
				op_valid = 1'b1;
			end else if (b == BYTE_SYSEX_START) begin
				in_message_d = 1'b1;
				msg_length_d = LEN_W'(1);
				if (stream_mode_q) begin
					op_valid = 1'b1;
				end else begin
					overflowed_d = 1'b0;
					op_valid     = 1'b1;
					op.kind      = OP_WRITE;
					op.addr      = '0;
				end
			end else if (in_message_q) begin
				if (b == BYTE_SYSEX_END) begin
					in_message_d = 1'b0;
					if (stream_mode_q) begin
						msg_length_d = len_inc;
						op_valid     = 1'b1;
					end else if (!overflowed_q && room) begin
						op_valid        = 1'b1;
						op.kind         = OP_WRITE;
						msg_length_d    = msg_length_q + 1'b1;
						replay_active_d = 1'b1;
						replay_index_d  = '0;
						pace_count_d    = 16'd0;
						replay_din_d    = to_d;
						replay_usb_d    = to_u;
					end else begin
						overflowed_d = 1'b1;
					end
				end else if (b[7]) begin
					in_message_d = 1'b0;
					op_valid     = 1'b1;
				end else if (stream_mode_q) begin
					msg_length_d = len_inc;
					op_valid     = 1'b1;
				end else if (room) begin
					op_valid     = 1'b1;
					op.kind      = OP_WRITE;
					msg_length_d = msg_length_q + 1'b1;
				end else begin
					overflowed_d = 1'b1;
				end
			end else begin
				op_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_mode_q   <= 1'b1;
			din_thru_q      <= 1'b0;
			byte_delay_q    <= 16'd0;
			in_message_q    <= 1'b0;
			overflowed_q    <= 1'b0;
			replay_active_q <= 1'b0;
			replay_din_q    <= 1'b0;
			replay_usb_q    <= 1'b0;
			msg_length_q    <= '0;
			replay_index_q  <= '0;
			pace_count_q    <= 16'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STREAM_MODE: stream_mode_q <= cfg_data[0];
					CFG_DIN_THRU:    din_thru_q    <= cfg_data[0];
					CFG_BYTE_DELAY:  byte_delay_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (accept) begin
				in_message_q    <= in_message_d;
				overflowed_q    <= overflowed_d;
				replay_active_q <= replay_active_d;
				replay_din_q    <= replay_din_d;
				replay_usb_q    <= replay_usb_d;
				msg_length_q    <= msg_length_d;
				replay_index_q  <= replay_index_d;
				pace_count_q    <= pace_count_d;
			end
		end
	end

	// bytes are dropped during replay, so no message can open under it
	a_replay_no_msg: assert property (@(posedge clk) disable iff (!arst_n)
		replay_active_q |-> !in_message_q)
		else $error("message open during replay");

	a_replay_index: assert property (@(posedge clk) disable iff (!arst_n)
		replay_active_q |-> (replay_index_q < msg_length_q))
		else $error("replay index past message length");

	a_replay_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(replay_active_q) |-> (replay_index_q == '0) && (pace_count_q == 16'd0)
			&& (msg_length_q >= LEN_W'(2)))
		else $error("replay started with stale pointers");

endmodule

// ===== hdl/msr_queue.sv =====
// Short queue of operations between front end and back end.
`timescale 1ns / 1ps
module msr_queue import msr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output op_t  q_op
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam logic [PW:0] DEPTH_C = (PW+1)'(QUEUE_DEPTH);

	op_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == DEPTH_C);
	assign q_valid = (count_q != '0);
	assign q_op    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/msr_back.sv =====
// Back end: SysEx message store, read stage and output register.
`timescale 1ns / 1ps
module msr_back import msr_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  op_t       q_op,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [7:0] mem_q [BUFFER_DEPTH];
	logic [7:0] rd_data_q;
	logic       s1_valid;
	op_t        op_s1;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       out_load, s1_ready, is_write;
	out_item_t  result;

	assign is_write  = (q_op.kind == OP_WRITE);
	assign out_load  = !out_valid_q || out_ready;
	assign s1_ready  = !s1_valid || out_load;
	assign pop       = q_valid && (is_write || s1_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (pop && is_write)
			mem_q[q_op.addr[AW-1:0]] <= q_op.data;
		if (pop && (q_op.kind == OP_READ))
			rd_data_q <= mem_q[q_op.addr[AW-1:0]];
	end

	always_comb begin
		result.out_byte    = op_s1.data;
		result.to_din      = op_s1.to_din;
		result.to_usb      = op_s1.to_usb;
		result.replay_last = op_s1.last;
		if (op_s1.kind == OP_READ)
			result.out_byte = op_s1.zero ? 8'd0 : rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready)
				s1_valid <= pop && !is_write;
			if (out_load)
				out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && pop)
			op_s1 <= q_op;
		if (out_load && s1_valid)
			out_q <= result;
	end

endmodule

// ===== test/msr_tx_checker.sv =====
// Checker: mirrors the router's registers and state, predicts every transmitted byte and compares.
`timescale 1ns / 1ps
module msr_tx_checker import msr_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	output int                    errors,
	output int                    pending,
	output int                    checked,
	output logic                  replay_busy
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic stream_on;
	logic thru_on;
	logic [15:0] tick_gap_cfg;

	logic in_sysex;
	logic [LEN_W-1:0] sysex_len;
	logic lost;
	logic [7:0] sysex_buf [BUFFER_DEPTH];
	logic replaying;
	logic [LEN_W-1:0] replay_pos;
	logic [15:0] pace;
	logic rep_din;
	logic rep_usb;

	out_item_t tx_due [$];
	int fails;
	int n_checked;

	function automatic out_item_t tx_item(input logic [7:0] b, input logic d, input logic u,
			input logic last);
		out_item_t t;
		t.out_byte    = b;
		t.to_din      = d;
		t.to_usb      = u;
		t.replay_last = last;
		return t;
	endfunction

	task automatic pace_tick(output logic got, output out_item_t t);
		logic [15:0] span;
		logic [7:0] b;
		got = 1'b0;
		t   = '0;
		if (!replaying)
			return;
		if (pace != 16'hFFFF)
			pace = pace + 16'd1;
		span = (tick_gap_cfg == 16'd0) ? 16'd1 : tick_gap_cfg;
		if (pace < span)
			return;
		pace = '0;
		b = (int'(replay_pos) < BUFFER_DEPTH) ? sysex_buf[replay_pos[AW-1:0]] : 8'h00;
		t = tx_item(b, rep_din, rep_usb, int'(replay_pos) + 1 >= int'(sysex_len));
		replay_pos = replay_pos + 1'b1;
		if (t.replay_last)
			replaying = 1'b0;
		got = 1'b1;
	endtask

	task automatic route_byte(input logic [7:0] b, input logic usb, output logic got,
			output out_item_t t);
		logic d;
		logic u;
		logic room;
		d    = usb | thru_on;
		u    = ~usb;
		got  = 1'b0;
		t    = tx_item(b, d, u, 1'b0);
		room = (int'(sysex_len) < BUFFER_DEPTH) && (sysex_len < LEN_MAX);
		if (replaying)
			return;
		if (b >= BYTE_REALTIME) begin
			got = 1'b1;
			return;
		end
		if (b == BYTE_SYSEX_START) begin
			in_sysex  = 1'b1;
			sysex_len = LEN_W'(1);
			if (stream_on) begin
				got = 1'b1;
			end else begin
				lost         = 1'b0;
				sysex_buf[0] = b;
			end
			return;
		end
		if (in_sysex && b == BYTE_SYSEX_END) begin
			in_sysex = 1'b0;
			if (stream_on) begin
				if (sysex_len != LEN_MAX)
					sysex_len = sysex_len + 1'b1;
				got = 1'b1;
			end else if (!lost && room) begin
				sysex_buf[sysex_len[AW-1:0]] = b;
				sysex_len  = sysex_len + 1'b1;
				replaying  = 1'b1;
				replay_pos = '0;
				pace       = '0;
				rep_din    = d;
				rep_usb    = u;
			end else begin
				lost = 1'b1;
			end
			return;
		end
		if (in_sysex && b[7]) begin
			in_sysex = 1'b0;
		end else if (in_sysex) begin
			if (stream_on) begin
				if (sysex_len != LEN_MAX)
					sysex_len = sysex_len + 1'b1;
				got = 1'b1;
			end else if (room) begin
				sysex_buf[sysex_len[AW-1:0]] = b;
				sysex_len = sysex_len + 1'b1;
			end else begin
				lost = 1'b1;
			end
			return;
		end
		got = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic got;
		out_item_t res;
		out_item_t want;
		if (!arst_n) begin
			stream_on    = 1'b1;
			thru_on      = 1'b0;
			tick_gap_cfg = '0;
			in_sysex     = 1'b0;
			sysex_len    = '0;
			lost         = 1'b0;
			replaying    = 1'b0;
			replay_pos   = '0;
			pace         = '0;
			rep_din      = 1'b0;
			rep_usb      = 1'b0;
			tx_due.delete();
			fails        = 0;
			n_checked    = 0;
			errors      <= 0;
			pending     <= 0;
			checked     <= 0;
			replay_busy <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STREAM_MODE: stream_on    = cfg_data[0];
					CFG_DIN_THRU:    thru_on      = cfg_data[0];
					CFG_BYTE_DELAY:  tick_gap_cfg = cfg_data[15:0];
					default: ;
				endcase
			end
			// results first: a transfer on this edge cannot belong to an item taken on it
			if (out_valid && out_ready) begin
				if (tx_due.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected transfer byte %02h din %b usb %b last %b",
							$time, out_data.out_byte, out_data.to_din, out_data.to_usb,
							out_data.replay_last);
					fails++;
				end else begin
					want = tx_due.pop_front();
					n_checked++;
					if (want !== out_data) begin
						if (fails < 10)
							$display({"%0t: mismatch, expected byte %02h din %b usb %b last %b,",
								" got byte %02h din %b usb %b last %b"}, $time,
								want.out_byte, want.to_din, want.to_usb, want.replay_last,
								out_data.out_byte, out_data.to_din, out_data.to_usb,
								out_data.replay_last);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.req_type == REQ_TICK)
					pace_tick(got, res);
				else
					route_byte(in_data.midi_byte, in_data.from_usb, got, res);
				if (got)
					tx_due.push_back(res);
			end
			errors      <= fails;
			pending     <= tx_due.size();
			checked     <= n_checked;
			replay_busy <= replaying;
		end
	end

endmodule

// ===== test/midi_sysex_router_pacer_unit_tb.sv =====
// Testbench top: drives MIDI bytes, ticks and register writes into the router and reports the verdict.
`timescale 1ns / 1ps
module midi_sysex_router_pacer_unit_tb;
	import msr_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	int errors;
	int pending;
	int checked;
	logic replay_busy;

	int sent = 0;
	int cfg_sets = 0;
	int cycles = 0;
	int calm [2] = '{0, 0};
	bit no_gaps = 1'b0;
	logic cur_stream = 1'b1;
	logic [15:0] cur_delay = '0;

	// stream_mode, din_thru, byte_delay per random phase
	logic [17:0] plan [8] = '{
		{1'b1, 1'b0, 16'd0}, {1'b0, 1'b0, 16'd1}, {1'b0, 1'b1, 16'd2}, {1'b1, 1'b1, 16'd3},
		{1'b0, 1'b0, 16'd0}, {1'b0, 1'b1, 16'd3}, {1'b1, 1'b0, 16'hFFFF}, {1'b0, 1'b1, 16'd1}
	};

	midi_sysex_router_pacer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	msr_tx_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked),
		.replay_busy(replay_busy)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int pause_len(input int side);
		int r;
		if (calm[side] > 0) begin
			calm[side]--;
			return 0;
		end
		if ($urandom_range(63) == 0) begin
			calm[side] = $urandom_range(100, 20);
			return 0;
		end
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 97)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	always @(posedge clk) begin
		int hold;
		if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			hold = pause_len(1);
		end
	end

	task automatic send(input logic typ, input logic [7:0] b, input logic usb);
		int g;
		g = no_gaps ? 0 : pause_len(0);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{req_type: typ, midi_byte: b, from_usb: usb};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic set_config(input logic sm, input logic dt, input logic [15:0] dly);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_STREAM_MODE;
		cfg_data  <= {15'($urandom), sm};
		@(posedge clk);
		cfg_index <= CFG_DIN_THRU;
		cfg_data  <= {15'($urandom), dt};
		@(posedge clk);
		cfg_index <= CFG_BYTE_DELAY;
		cfg_data  <= dly;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_stream = sm;
		cur_delay  = dly;
		cfg_sets++;
	endtask

	// drain any replay, close an open message, then let the block go idle
	task automatic finish_phase();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replay_busy)
			send(REQ_TICK, 8'($urandom), 1'($urandom));
		send(REQ_BYTE, STATUS_NOTE_OFF, 1'b0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		no_gaps = 1'b0;
	endtask

	task automatic burst();
		int k;
		int len;
		int n;
		int span;
		logic usb;
		logic [7:0] b;
		k    = $urandom_range(99);
		usb  = 1'($urandom);
		span = (cur_delay == 16'd0) ? 1 : int'(cur_delay);
		if (k < 50) begin
			send(REQ_BYTE, BYTE_SYSEX_START, usb);
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
			repeat (len) begin
				if ($urandom_range(9) == 0)
					send(REQ_BYTE, 8'($urandom_range(255, 248)), 1'($urandom));
				send(REQ_BYTE, 8'($urandom_range(127, 0)), ($urandom_range(3) == 0) ? ~usb : usb);
			end
			k = $urandom_range(19);
			if (k < 17) begin
				send(REQ_BYTE, BYTE_SYSEX_END, 1'($urandom));
				if (!cur_stream) begin
					n = (len + 2) * span + $urandom_range(2);
					repeat (n) begin
						if ($urandom_range(29) == 0)
							send(REQ_BYTE, 8'($urandom), 1'($urandom));
						send(REQ_TICK, 8'($urandom), 1'($urandom));
					end
				end
			end else if (k < 19) begin
				b = 8'($urandom_range(246, 128));
				if (b == BYTE_SYSEX_START)
					b = STATUS_NOTE_OFF;
				send(REQ_BYTE, b, usb);
			end
		end else if (k < 70) begin
			send(REQ_BYTE, 8'($urandom_range(239, 128)), usb);
			repeat ($urandom_range(2, 1))
				send(REQ_BYTE, 8'($urandom_range(127, 0)), usb);
		end else if (k < 80) begin
			send(REQ_BYTE, 8'($urandom_range(255, 248)), usb);
		end else if (k < 90) begin
			repeat ($urandom_range(4, 1))
				send(REQ_TICK, 8'($urandom), usb);
		end else begin
			repeat ($urandom_range(3, 1))
				send(REQ_BYTE, 8'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: streaming, no thru
		send(REQ_BYTE, BYTE_REALTIME, 1'b1);
		send(REQ_BYTE, 8'hFF, 1'b0);
		send(REQ_BYTE, BYTE_SYSEX_START, 1'b0);
		send(REQ_BYTE, 8'h00, 1'b0);
		send(REQ_BYTE, 8'h7F, 1'b1);
		send(REQ_BYTE, 8'hFA, 1'b0);
		send(REQ_BYTE, BYTE_SYSEX_END, 1'b1);
		send(REQ_TICK, 8'hA5, 1'b1);
		send(REQ_BYTE, 8'h45, 1'b0);
		send(REQ_BYTE, BYTE_SYSEX_END, 1'b0);
		send(REQ_BYTE, BYTE_SYSEX_START, 1'b1);
		send(REQ_BYTE, 8'hC3, 1'b0);
		send(REQ_BYTE, 8'h12, 1'b0);
		finish_phase();

		// buffered with thru: replay, byte dropped during replay, abort, stray end
		set_config(1'b0, 1'b1, 16'd0);
		send(REQ_BYTE, BYTE_SYSEX_START, 1'b1);
		send(REQ_BYTE, 8'h00, 1'b0);
		send(REQ_BYTE, 8'h7F, 1'b1);
		send(REQ_BYTE, BYTE_REALTIME, 1'b0);
		send(REQ_BYTE, BYTE_SYSEX_END, 1'b0);
		send(REQ_BYTE, 8'h55, 1'b1);
		repeat (5) send(REQ_TICK, 8'h5A, 1'b0);
		send(REQ_BYTE, BYTE_SYSEX_START, 1'b0);
		send(REQ_BYTE, 8'h01, 1'b0);
		send(REQ_BYTE, 8'h90, 1'b1);
		send(REQ_BYTE, BYTE_SYSEX_END, 1'b1);
		finish_phase();

		for (int p = 0; p < 8; p++) begin
			set_config(plan[p][17], plan[p][16], plan[p][15:0]);
			start = sent;
			while (sent - start < 150)
				burst();
			finish_phase();
		end

		// slowest pacing, then a lower delay that takes effect mid-replay
		set_config(1'b0, 1'b1, 16'hFFFF);
		send(REQ_BYTE, BYTE_SYSEX_START, 1'b1);
		send(REQ_BYTE, 8'h3C, 1'b1);
		send(REQ_BYTE, BYTE_SYSEX_END, 1'b0);
		repeat (4) send(REQ_TICK, 8'($urandom), 1'($urandom));
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		set_config(1'b0, 1'b1, 16'd2);
		no_gaps = 1'b1;
		finish_phase();

		$display("%0d items sent over %0d register settings, %0d transmitted bytes checked",
			sent, cfg_sets + 1, checked);
		$display("covered routing, thru, SysEx streaming and buffering, aborts, pacing changes");
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== midi_sysex_router_pacer_unit.f =====
hdl/msr_pkg.sv
hdl/msr_front.sv
hdl/msr_queue.sv
hdl/msr_back.sv
hdl/midi_sysex_router_pacer_unit.sv
test/msr_tx_checker.sv
test/midi_sysex_router_pacer_unit_tb.sv
